// ===== sv/plcl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the piecewise-linear curve lookup.
package plcl_pkg;

   localparam int CHANNELS   = 4;
   localparam int MAX_POINTS = 16;
   localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int VAL_W      = 20;

   typedef enum logic [1:0] {
      ACT_SAMPLE  = 2'd0,
      ACT_ADD     = 2'd1,
      ACT_CLEAR   = 2'd2,
      ACT_RESTORE = 2'd3
   } action_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic signed [VAL_W-1:0] ONE_Q16 = 20'sd65536;

   typedef struct packed {
      logic [1:0]              action;
      logic [2:0]              channel;
      logic signed [VAL_W-1:0] x_value;
      logic signed [VAL_W-1:0] y_value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] curve_value;
      logic [1:0]              status;
   } rsp_type;

   typedef struct packed {
      logic                    insert;
      logic                    restore;
      logic [CH_W-1:0]         ch;
      logic [CNT_W-1:0]        count;
      logic signed [VAL_W-1:0] key;
      logic signed [VAL_W-1:0] val;
   } cell_cmd_type;

endpackage

// ===== sv/plcl_cell.sv =====
`timescale 1ns / 1ps
// One control-point slot for every channel, shifting to the right on insert.
module plcl_cell (
   input  logic                             clock,
   input  logic [plcl_pkg::CNT_W-1:0]       slot,
   input  plcl_pkg::cell_cmd_type           cmd,
   input  logic                             left_le,
   input  logic signed [plcl_pkg::VAL_W-1:0] left_x,
   input  logic signed [plcl_pkg::VAL_W-1:0] left_y,
   output logic                             le,
   output logic signed [plcl_pkg::VAL_W-1:0] pt_x,
   output logic signed [plcl_pkg::VAL_W-1:0] pt_y
);

   logic signed [plcl_pkg::VAL_W-1:0] x_ff [plcl_pkg::CHANNELS];
   logic signed [plcl_pkg::VAL_W-1:0] y_ff [plcl_pkg::CHANNELS];
   logic                              in_use;
   logic                              take_new;
   logic                              take_left;

   assign pt_x      = x_ff[cmd.ch];
   assign pt_y      = y_ff[cmd.ch];
   assign in_use    = slot < cmd.count;
   assign le        = in_use && (pt_x <= cmd.key);
   assign take_new  = !le && (slot <= cmd.count) && ((slot == '0) || left_le);
   assign take_left = !le && (slot <= cmd.count) && (slot != '0) && !left_le;

   always_ff @(posedge clock) begin
      if (cmd.restore) begin
         for (int c = 0; c < plcl_pkg::CHANNELS; c++) begin
            if (slot == '0) begin
               x_ff[c] <= '0;
               y_ff[c] <= '0;
            end else if (slot == plcl_pkg::CNT_W'(1)) begin
               x_ff[c] <= plcl_pkg::ONE_Q16;
               y_ff[c] <= plcl_pkg::ONE_Q16;
            end
         end
      end else if (cmd.insert) begin
         if (take_new) begin
            x_ff[cmd.ch] <= cmd.key;
            y_ff[cmd.ch] <= cmd.val;
         end else if (take_left) begin
            x_ff[cmd.ch] <= left_x;
            y_ff[cmd.ch] <= left_y;
         end
      end
   end

endmodule

// ===== sv/plcl_divider.sv =====
`timescale 1ns / 1ps
// Serial restoring divider: one quotient bit per cycle, sign applied at the end.
module plcl_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [41:0]       dividend,
   input  logic [20:0]              divisor,
   output logic                     done,
   output logic signed [21:0]       quotient
);

   logic [41:0] rem_ff, rem_in;
   logic [20:0] den_ff, den_in;
   logic [20:0] q_ff, q_in;
   logic        neg_ff, neg_in;
   logic [4:0]  bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic [41:0] den_sh;

   assign den_sh   = 42'(den_ff) << bit_ff;
   assign done     = busy_ff && (bit_ff == '0);
   assign quotient = neg_ff ? -$signed({1'b0, q_in}) : $signed({1'b0, q_in});

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = dividend[41] ? 42'(-dividend) : 42'(dividend);
         neg_in  = dividend[41];
         den_in  = divisor;
         q_in    = '0;
         bit_in  = 5'd20;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= den_sh) begin
            rem_in = rem_ff - den_sh;
            q_in   = q_ff | (21'd1 << bit_ff);
         end
         if (bit_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            bit_in = bit_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      bit_ff <= bit_in;
   end

endmodule

// ===== sv/piecewise_linear_curve_lookup.sv =====
`timescale 1ns / 1ps
// Piecewise-linear curve lookup over per-channel sorted control-point tables.
// The block takes one item at a time. Add point, clear channel, reset all and
// samples that clamp or pass through go from ST_EXEC straight to ST_DONE;
// a sample between two points also passes ST_MUL, ST_DIV, ST_WAIT and ST_FIN,
// waiting there on the 21-step serial divider that follows the point selection
// and the multiply. Points live in a row of MAX_POINTS slot cells that shift
// right by one on insert, so all slots update together whatever the position.
module piecewise_linear_curve_lookup (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plcl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plcl_pkg::rsp_type rsp_data
);

   localparam int NP = plcl_pkg::MAX_POINTS;
   localparam int VW = plcl_pkg::VAL_W;
   localparam int CW = plcl_pkg::CNT_W;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_EXEC = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_DIV  = 7'b0001000,
      ST_WAIT = 7'b0010000,
      ST_FIN  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   plcl_pkg::req_type  item_ff, item_in;
   plcl_pkg::rsp_type  res_ff, res_in;
   plcl_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]      cnt_ff [plcl_pkg::CHANNELS];
   logic [CW-1:0]      cnt_in [plcl_pkg::CHANNELS];
   logic signed [20:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [20:0]        den_ff, den_in;
   logic signed [VW-1:0] ly_ff, ly_in;
   logic signed [41:0] prod_ff, prod_in;

   plcl_pkg::cell_cmd_type cmd;
   logic                   le   [NP+1];
   logic signed [VW-1:0]   px   [NP];
   logic signed [VW-1:0]   py   [NP];
   logic signed [VW-1:0]   lx, ly, hx, hy, lastx, lasty;
   logic [plcl_pkg::CH_W-1:0] ch;
   logic                   in_range;
   logic [CW-1:0]          n;
   logic                   full;
   logic                   div_start;
   logic                   div_done;
   logic signed [21:0]     quot;

   assign ch       = item_ff.channel[plcl_pkg::CH_W-1:0];
   assign in_range = {1'b0, item_ff.channel} < 4'(plcl_pkg::CHANNELS);
   assign n        = cnt_ff[ch];
   assign full     = n >= CW'(NP);

   always_comb begin
      cmd.insert  = (state_ff == ST_EXEC) && (item_ff.action == plcl_pkg::ACT_ADD)
                    && in_range && !full;
      cmd.restore = reset ||
                    ((state_ff == ST_EXEC) && (item_ff.action == plcl_pkg::ACT_RESTORE));
      cmd.ch      = ch;
      cmd.count   = n;
      cmd.key     = item_ff.x_value;
      cmd.val     = item_ff.y_value;
   end

   assign le[0] = 1'b0;

   for (genvar k = 0; k < NP; k++) begin : g_cell
      plcl_cell u_cell (
         .clock   (clock),
         .slot    (CW'(k)),
         .cmd     (cmd),
         .left_le (le[k]),
         .left_x  ((k == 0) ? px[0] : px[(k == 0) ? 0 : k - 1]),
         .left_y  ((k == 0) ? py[0] : py[(k == 0) ? 0 : k - 1]),
         .le      (le[k+1]),
         .pt_x    (px[k]),
         .pt_y    (py[k])
      );
   end

   always_comb begin
      lx = '0;
      ly = '0;
      hx = '0;
      hy = '0;
      lastx = '0;
      lasty = '0;
      for (int k = 0; k < NP; k++) begin
         if (le[k+1] && !((k + 1 < NP) ? le[(k + 2 > NP) ? NP : k + 2] : 1'b0)) begin
            lx = lx | px[k];
            ly = ly | py[k];
         end
         if (k > 0 && le[k] && !le[k+1]) begin
            hx = hx | px[k];
            hy = hy | py[k];
         end
         if (CW'(k) == n - CW'(1)) begin
            lastx = lastx | px[k];
            lasty = lasty | py[k];
         end
      end
   end

   plcl_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (quot)
   );

   assign div_start = (state_ff == ST_DIV);
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      cnt_in       = cnt_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      den_in       = den_ff;
      ly_in        = ly_ff;
      prod_in      = prod_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in.curve_value = '0;
            res_in.status      = plcl_pkg::STATUS_OK;
            state_in           = ST_DONE;
            case (item_ff.action)
               plcl_pkg::ACT_SAMPLE: begin
                  if (!in_range) begin
                     res_in.curve_value = item_ff.x_value;
                     res_in.status      = plcl_pkg::STATUS_RANGE;
                  end else if (n == '0) begin
                     res_in.curve_value = item_ff.x_value;
                  end else if (item_ff.x_value <= px[0]) begin
                     res_in.curve_value = py[0];
                  end else if (item_ff.x_value >= lastx) begin
                     res_in.curve_value = lasty;
                  end else begin
                     dx_in    = 21'(item_ff.x_value) - 21'(lx);
                     dy_in    = 21'(hy) - 21'(ly);
                     den_in   = 21'(21'(hx) - 21'(lx));
                     ly_in    = ly;
                     state_in = ST_MUL;
                  end
               end
               plcl_pkg::ACT_ADD: begin
                  if (!in_range) begin
                     res_in.status = plcl_pkg::STATUS_RANGE;
                  end else if (full) begin
                     res_in.status = plcl_pkg::STATUS_FULL;
                  end else begin
                     cnt_in[ch] = n + CW'(1);
                  end
               end
               plcl_pkg::ACT_CLEAR: begin
                  if (!in_range) begin
                     res_in.status = plcl_pkg::STATUS_RANGE;
                  end else begin
                     cnt_in[ch] = '0;
                  end
               end
               default: begin
                  for (int c = 0; c < plcl_pkg::CHANNELS; c++) begin
                     cnt_in[c] = CW'(2);
                  end
               end
            endcase
         end
         ST_MUL: begin
            prod_in  = dx_ff * dy_ff;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            res_in.curve_value = VW'(22'(ly_ff) + quot);
            res_in.status      = plcl_pkg::STATUS_OK;
            state_in           = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < plcl_pkg::CHANNELS; c++) begin
            cnt_ff[c] <= CW'(2);
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      item_ff <= item_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      den_ff  <= den_in;
      ly_ff   <= ly_in;
      prod_ff <= prod_in;
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the piecewise-linear curve lookup.
module tb_top;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   plcl_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   plcl_pkg::rsp_type rsp_data;

   piecewise_linear_curve_lookup i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   logic signed [plcl_pkg::VAL_W-1:0] curve_x [plcl_pkg::CHANNELS][plcl_pkg::MAX_POINTS];
   logic signed [plcl_pkg::VAL_W-1:0] curve_y [plcl_pkg::CHANNELS][plcl_pkg::MAX_POINTS];
   int                                curve_len [plcl_pkg::CHANNELS];
   plcl_pkg::rsp_type                 pending_rsp [$];
   int                                error_count = 0;
   int                                sent_count = 0;
   int                                rsp_count = 0;
   bit                                sender_gaps = 1;
   bit                                receiver_gaps = 1;
   bit                                long_hold_req = 0;
   int                                hold_cycles = 0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic void restore_curves();
      for (int c = 0; c < plcl_pkg::CHANNELS; c++) begin
         curve_x[c][0] = '0;
         curve_y[c][0] = '0;
         curve_x[c][1] = plcl_pkg::ONE_Q16;
         curve_y[c][1] = plcl_pkg::ONE_Q16;
         curve_len[c] = 2;
      end
   endfunction

   function automatic logic signed [plcl_pkg::VAL_W-1:0] interpolate(
         int c, logic signed [plcl_pkg::VAL_W-1:0] x);
      int                lo;
      int                hi;
      int                mid;
      int                n;
      longint            lx;
      longint            ly;
      longint            hx;
      longint            hy;
      longint            q;
      n = curve_len[c];
      if (n == 0) return x;
      if (x <= curve_x[c][0]) return curve_y[c][0];
      if (x >= curve_x[c][n-1]) return curve_y[c][n-1];
      lo = 0;
      hi = n;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (curve_x[c][mid] > x) hi = mid;
         else lo = mid + 1;
      end
      hx = curve_x[c][lo];
      hy = curve_y[c][lo];
      lx = curve_x[c][lo-1];
      ly = curve_y[c][lo-1];
      q = ((longint'(x) - lx) * (hy - ly)) / (hx - lx);
      return plcl_pkg::VAL_W'(ly + q);
   endfunction

   function automatic plcl_pkg::rsp_type apply_item(plcl_pkg::req_type r);
      plcl_pkg::rsp_type o;
      int                c;
      int                pos;
      o = '0;
      c = int'(r.channel);
      case (plcl_pkg::action_type'(r.action))
         plcl_pkg::ACT_SAMPLE: begin
            if (c < plcl_pkg::CHANNELS) o.curve_value = interpolate(c, r.x_value);
            else begin
               o.curve_value = r.x_value;
               o.status = plcl_pkg::STATUS_RANGE;
            end
         end
         plcl_pkg::ACT_ADD: begin
            if (c >= plcl_pkg::CHANNELS) o.status = plcl_pkg::STATUS_RANGE;
            else if (curve_len[c] >= plcl_pkg::MAX_POINTS) o.status = plcl_pkg::STATUS_FULL;
            else begin
               pos = 0;
               while (pos < curve_len[c] && curve_x[c][pos] <= r.x_value) pos++;
               for (int k = curve_len[c]; k > pos; k--) begin
                  curve_x[c][k] = curve_x[c][k-1];
                  curve_y[c][k] = curve_y[c][k-1];
               end
               curve_x[c][pos] = r.x_value;
               curve_y[c][pos] = r.y_value;
               curve_len[c]++;
            end
         end
         plcl_pkg::ACT_CLEAR: begin
            if (c < plcl_pkg::CHANNELS) curve_len[c] = 0;
            else o.status = plcl_pkg::STATUS_RANGE;
         end
         default: restore_curves();
      endcase
      return o;
   endfunction

   task automatic send_item(plcl_pkg::action_type act, int ch, int x, int y);
      plcl_pkg::req_type r;
      int                gap;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.action = act;
      r.channel = 3'(ch);
      r.x_value = plcl_pkg::VAL_W'(x);
      r.y_value = plcl_pkg::VAL_W'(y);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.insert(pending_rsp.size(), apply_item(r));
      sent_count++;
   endtask

   function automatic int rand_val();
      return $urandom_range(0, 20'hFFFFF) - 524288;
   endfunction

   // receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (long_hold_req) begin
         long_hold_req <= 1'b0;
         hold_cycles <= 300;
         rsp_stall <= 1'b1;
      end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
         hold_cycles <= $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      plcl_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected transfer, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.curve_value !== want.curve_value) begin
               $display("%0t: curve_value expected %0d actual %0d", $time,
                        want.curve_value, rsp_data.curve_value);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed();
      send_item(plcl_pkg::ACT_SAMPLE, 0, 0, 0);
      send_item(plcl_pkg::ACT_SAMPLE, 1, 32768, 0);
      send_item(plcl_pkg::ACT_SAMPLE, 2, -524288, 0);
      send_item(plcl_pkg::ACT_SAMPLE, 3, 524287, 0);
      send_item(plcl_pkg::ACT_SAMPLE, 7, -12345, 0);
      send_item(plcl_pkg::ACT_SAMPLE, 4, 524287, 0);
      send_item(plcl_pkg::ACT_ADD, 0, 32768, -524288);
      send_item(plcl_pkg::ACT_ADD, 0, 32768, 524287);
      send_item(plcl_pkg::ACT_SAMPLE, 0, 32768, 0);
      send_item(plcl_pkg::ACT_SAMPLE, 0, 40000, 0);
      send_item(plcl_pkg::ACT_SAMPLE, 0, 10000, 0);
      send_item(plcl_pkg::ACT_ADD, 5, 1, 1);
      send_item(plcl_pkg::ACT_CLEAR, 6, 0, 0);
      send_item(plcl_pkg::ACT_CLEAR, 1, 0, 0);
      send_item(plcl_pkg::ACT_SAMPLE, 1, -777, 0);
      send_item(plcl_pkg::ACT_ADD, 1, 500, -3000);
      send_item(plcl_pkg::ACT_SAMPLE, 1, -524288, 0);
      send_item(plcl_pkg::ACT_SAMPLE, 1, 524287, 0);
      send_item(plcl_pkg::ACT_ADD, 1, -524288, 524287);
      send_item(plcl_pkg::ACT_SAMPLE, 1, 0, 0);
      for (int i = 0; i < 15; i++) send_item(plcl_pkg::ACT_ADD, 2, rand_val(), rand_val());
      send_item(plcl_pkg::ACT_SAMPLE, 2, rand_val(), 0);
      send_item(plcl_pkg::ACT_RESTORE, 7, 0, 0);
   endtask

   task automatic test_backpressure();
      long_hold_req = 1'b1;
      for (int i = 0; i < 12; i++)
         send_item(plcl_pkg::ACT_SAMPLE, i % 4, $urandom_range(0, 65536), 0);
   endtask

   task automatic test_random(int count);
      int                   ch;
      int                   pick;
      plcl_pkg::action_type act;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 3);
         if (pick < 55) act = plcl_pkg::ACT_SAMPLE;
         else if (pick < 88) act = plcl_pkg::ACT_ADD;
         else if (pick < 97) act = plcl_pkg::ACT_CLEAR;
         else act = plcl_pkg::ACT_RESTORE;
         if ($urandom_range(0, 1)) send_item(act, ch, rand_val(), rand_val());
         else send_item(act, ch, $urandom_range(0, 131072) - 32768, rand_val());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      restore_curves();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(600);
      sender_gaps = 0;
      receiver_gaps = 0;
      test_random(150);
      req_valid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d items over all four actions, clamping, full tables,", sent_count);
      $display("bad channels and a long receiver hold; checked %0d results.", rsp_count);
      if (error_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_top: errors");
      $finish;
   end

endmodule
